// ----- hdl/hne_pkg.sv -----
// Shared constants, configuration codes and request types for the heightmap normal engine.
package hne_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_HEIGHT_SCALE = 2'd2;
    localparam logic [1:0] CFG_HEIGHT_FLOOR = 2'd3;

    localparam logic [10:0] RST_FRAME_WIDTH = 11'd1024;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [7:0] RST_HEIGHT_SCALE = 8'd60;
    localparam logic [7:0] RST_HEIGHT_FLOOR = 8'd10;

    localparam logic [16:0] RECIP_255 = 17'd65793;
    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [31:0] Y_TERM_SQ = 32'd262144;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [7:0]  height_scale;
        logic [7:0]  height_floor;
        logic        restart;
    } hne_cfg_t;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] down;
        logic [7:0] up;
        logic [7:0] center;
        logic [9:0] col;
        logic [9:0] row;
        logic       done;
    } hne_req_t;

endpackage

// ----- hdl/heightmap_normal_engine_core.sv -----
// Top level of the heightmap normal engine: configuration registers and part wiring.
//
// Heightmap bytes enter in raster order on the sample channel (sample_valid, sample_stall);
// a request is taken at a clock edge with sample_valid high and sample_stall low.
// Each pixel of row z>0 yields the unit normal of pixel (x, z-1); pixels of the last row
// also yield the normals of that row, so one sample gives zero to three results.
// Results leave on the result channel (result_valid, result_stall) as Q1.14 normals
// with the pixel's Q8.8 height, its coordinates and an end-of-frame flag.
// The front part takes a sample and returns to idle when nothing yields a result (first
// row); otherwise it passes through the read states F_RD0 to F_RD3, reading the three
// line stores one address per store and cycle, and then pushes its results in F_PUSH,
// waiting there while the queue is full. The back part takes one request at a time:
// five height mappings (B_H1 to B_H3), the squared lengths, then three binary searches,
// each of about fifteen steps through B_CHK to B_CMP. It sets the sustained rate.
// A four-entry request queue lets the front keep taking samples while the back works.
// When the receiver stalls, the result register holds its request and the back part
// waits; samples keep flowing until the queue is full.
// Reset clears all control state, not the line stores. A width or height write restarts
// the frame. Write configuration only while idle: the block itself does not enforce it.
module heightmap_normal_engine_core import hne_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic [7:0]         sample,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] normal_x,
    output logic [14:0]        normal_y,
    output logic signed [15:0] normal_z,
    output logic [15:0]        terrain_height,
    output logic [9:0]         column,
    output logic [9:0]         row,
    output logic               frame_done
);

    logic [10:0] frame_width_reg, frame_width_next;
    logic [10:0] frame_height_reg, frame_height_next;
    logic [7:0] height_scale_reg, height_scale_next;
    logic [7:0] height_floor_reg, height_floor_next;
    logic restart;
    hne_cfg_t cfg;
    hne_req_t push_req;
    hne_req_t head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    always_comb
    begin
        frame_width_next = frame_width_reg;
        frame_height_next = frame_height_reg;
        height_scale_next = height_scale_reg;
        height_floor_next = height_floor_reg;
        restart = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    frame_width_next = cfg_data;
                    restart = 1'b1;
                end
                CFG_FRAME_HEIGHT:
                begin
                    frame_height_next = cfg_data;
                    restart = 1'b1;
                end
                CFG_HEIGHT_SCALE:
                begin
                    height_scale_next = cfg_data[7:0];
                end
                CFG_HEIGHT_FLOOR:
                begin
                    height_floor_next = cfg_data[7:0];
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            height_scale_reg <= RST_HEIGHT_SCALE;
            height_floor_reg <= RST_HEIGHT_FLOOR;
        end
        else
        begin
            frame_width_reg <= frame_width_next;
            frame_height_reg <= frame_height_next;
            height_scale_reg <= height_scale_next;
            height_floor_reg <= height_floor_next;
        end
    end

    assign cfg.frame_width = frame_width_reg;
    assign cfg.frame_height = frame_height_reg;
    assign cfg.height_scale = height_scale_reg;
    assign cfg.height_floor = height_floor_reg;
    assign cfg.restart = restart;

    hne_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample      (sample),
        .full        (full),
        .push        (push),
        .req         (push_req)
    );

    hne_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_req),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    hne_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .empty         (empty),
        .head          (head),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .terrain_height(terrain_height),
        .column        (column),
        .row           (row),
        .frame_done    (frame_done)
    );

endmodule

// ----- hdl/hne_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/hne_front.sv -----
// Front part: accepts heightmap bytes, keeps the three line stores and builds normal requests.
module hne_front import hne_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  hne_cfg_t cfg,
    input  logic     sample_valid,
    output logic     sample_stall,
    input  logic [7:0] sample,
    input  logic     full,
    output logic     push,
    output hne_req_t req
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = AW + 1;
    localparam int CW = (WW > 11) ? WW : 11;

    typedef enum logic [2:0] {F_IDLE, F_RD0, F_RD1, F_RD2, F_RD3, F_PUSH} fstate_t;

    fstate_t state_reg, state_next;
    logic [AW-1:0] col_reg, col_next;
    logic [9:0] row_reg, row_next;
    logic [1:0] bank_reg, bank_next;
    logic [1:0] ibank_reg, ibank_next;
    logic [7:0] sample_reg, sample_next;
    logic [AW-1:0] x_reg, x_next;
    logic [AW-1:0] xl_reg, xl_next;
    logic [AW-1:0] xr_reg, xr_next;
    logic [AW-1:0] pl_reg, pl_next;
    logic [9:0] z_reg, z_next;
    logic [2:0] pend_reg, pend_next;
    logic [7:0] d_pl_reg, d_pl_next;
    logic [7:0] d_old_reg, d_old_next;
    logic [7:0] d_cpl_reg, d_cpl_next;
    logic [7:0] d_pr_reg, d_pr_next;
    logic [7:0] d_cpx_reg, d_cpx_next;
    logic [7:0] d_pc_reg, d_pc_next;

    logic [CW-1:0] w_ext;
    logic [WW-1:0] eff_w;
    logic [10:0] eff_h;
    logic accept;
    logic last_col;
    logic last_row;
    logic [1:0] pb;
    logic [1:0] ob;
    logic [AW-1:0] prev_addr;
    logic [AW-1:0] cur_addr;
    logic [7:0] rdata [3];
    logic [7:0] prev_data;
    logic [7:0] older_data;
    logic [7:0] cur_data;

    assign w_ext = CW'(cfg.frame_width);

    always_comb
    begin
        if (w_ext < CW'(2))
        begin
            eff_w = WW'(2);
        end
        else if (w_ext > CW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(w_ext);
        end
        if (cfg.frame_height < 11'd2)
        begin
            eff_h = 11'd2;
        end
        else if (cfg.frame_height > 11'(MAX_HEIGHT))
        begin
            eff_h = 11'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = cfg.frame_height;
        end
    end

    assign accept = sample_valid && (state_reg == F_IDLE);
    assign sample_stall = (state_reg != F_IDLE);
    assign last_col = (WW'(col_reg) == eff_w - WW'(1));
    assign last_row = ({1'b0, row_reg} == eff_h - 11'd1);

    assign pb = (ibank_reg == 2'd0) ? 2'd2 : ibank_reg - 2'd1;
    assign ob = (ibank_reg == 2'd2) ? 2'd0 : ibank_reg + 2'd1;

    always_comb
    begin
        case (state_reg)
            F_RD0:
            begin
                prev_addr = xl_reg;
                cur_addr = pl_reg;
            end
            F_RD1:
            begin
                prev_addr = xr_reg;
                cur_addr = xl_reg;
            end
            default:
            begin
                prev_addr = x_reg;
                cur_addr = xl_reg;
            end
        endcase
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_bank
        logic [AW-1:0] raddr;
        assign raddr = (pb == 2'(k)) ? prev_addr : ((ob == 2'(k)) ? x_reg : cur_addr);
        hne_ram #(
            .WIDTH(8),
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .clk  (clk),
            .we   (accept && (bank_reg == 2'(k))),
            .waddr(col_reg),
            .wdata(sample),
            .raddr(raddr),
            .rdata(rdata[k])
        );
    end

    assign prev_data = rdata[pb];
    assign older_data = rdata[ob];
    assign cur_data = rdata[ibank_reg];

    always_comb
    begin
        req = '0;
        if (pend_reg[0])
        begin
            req.left = d_pl_reg;
            req.right = d_pr_reg;
            req.down = (z_reg == 10'd1) ? d_pc_reg : d_old_reg;
            req.up = sample_reg;
            req.center = d_pc_reg;
            req.col = 10'(x_reg);
            req.row = z_reg - 10'd1;
            req.done = 1'b0;
        end
        else if (pend_reg[1])
        begin
            req.left = d_cpl_reg;
            req.right = sample_reg;
            req.down = d_pl_reg;
            req.up = d_cpx_reg;
            req.center = d_cpx_reg;
            req.col = 10'(xl_reg);
            req.row = z_reg;
            req.done = 1'b0;
        end
        else
        begin
            req.left = d_cpx_reg;
            req.right = sample_reg;
            req.down = d_pc_reg;
            req.up = sample_reg;
            req.center = sample_reg;
            req.col = 10'(x_reg);
            req.row = z_reg;
            req.done = 1'b1;
        end
    end

    assign push = (state_reg == F_PUSH) && (pend_reg != 3'd0) && !full;

    always_comb
    begin
        state_next = state_reg;
        col_next = col_reg;
        row_next = row_reg;
        bank_next = bank_reg;
        ibank_next = ibank_reg;
        sample_next = sample_reg;
        x_next = x_reg;
        xl_next = xl_reg;
        xr_next = xr_reg;
        pl_next = pl_reg;
        z_next = z_reg;
        pend_next = pend_reg;
        d_pl_next = d_pl_reg;
        d_old_next = d_old_reg;
        d_cpl_next = d_cpl_reg;
        d_pr_next = d_pr_reg;
        d_cpx_next = d_cpx_reg;
        d_pc_next = d_pc_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    sample_next = sample;
                    x_next = col_reg;
                    z_next = row_reg;
                    ibank_next = bank_reg;
                    xl_next = (col_reg == '0) ? col_reg : col_reg - AW'(1);
                    xr_next = last_col ? col_reg : col_reg + AW'(1);
                    pl_next = (col_reg >= AW'(2)) ? col_reg - AW'(2) : '0;
                    pend_next = {last_row && last_col, last_row && (col_reg != '0),
                                 row_reg != 10'd0};
                    if ((row_reg != 10'd0) || last_row)
                    begin
                        state_next = F_RD0;
                    end
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = last_row ? 10'd0 : row_reg + 10'd1;
                        bank_next = (bank_reg == 2'd2) ? 2'd0 : bank_reg + 2'd1;
                    end
                    else
                    begin
                        col_next = col_reg + AW'(1);
                    end
                end
                if (cfg.restart)
                begin
                    col_next = '0;
                    row_next = 10'd0;
                end
            end
            F_RD0:
            begin
                state_next = F_RD1;
            end
            F_RD1:
            begin
                d_pl_next = prev_data;
                d_old_next = older_data;
                d_cpl_next = cur_data;
                state_next = F_RD2;
            end
            F_RD2:
            begin
                d_pr_next = prev_data;
                d_cpx_next = cur_data;
                state_next = F_RD3;
            end
            F_RD3:
            begin
                d_pc_next = prev_data;
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push)
                begin
                    if (pend_reg[0])
                    begin
                        pend_next = {pend_reg[2:1], 1'b0};
                    end
                    else if (pend_reg[1])
                    begin
                        pend_next = {pend_reg[2], 2'b00};
                    end
                    else
                    begin
                        pend_next = 3'd0;
                    end
                end
                if (pend_next == 3'd0)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            bank_reg <= '0;
            ibank_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg <= col_next;
            row_reg <= row_next;
            bank_reg <= bank_next;
            ibank_reg <= ibank_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        x_reg <= x_next;
        xl_reg <= xl_next;
        xr_reg <= xr_next;
        pl_reg <= pl_next;
        z_reg <= z_next;
        d_pl_reg <= d_pl_next;
        d_old_reg <= d_old_next;
        d_cpl_reg <= d_cpl_next;
        d_pr_reg <= d_pr_next;
        d_cpx_reg <= d_cpx_next;
        d_pc_reg <= d_pc_next;
    end

endmodule

// ----- hdl/hne_queue.sv -----
// Short request queue between the front and back parts.
module hne_queue import hne_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  hne_req_t push_data,
    input  logic     pop,
    output hne_req_t head,
    output logic     full,
    output logic     empty
);

    localparam int QA = $clog2(QUEUE_DEPTH);

    hne_req_t mem_reg [QUEUE_DEPTH];
    logic [QA-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QA:0] count_reg, count_next;

    assign full = (count_reg == (QA + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QA'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QA'(1) : rd_ptr_reg;
        count_next = count_reg + (QA + 1)'(push) - (QA + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/hne_back.sv -----
// Back part: height mapping, squared lengths and an iterative normalizer for each request.
module hne_back import hne_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  hne_cfg_t           cfg,
    input  logic               empty,
    input  hne_req_t           head,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] normal_x,
    output logic [14:0]        normal_y,
    output logic signed [15:0] normal_z,
    output logic [15:0]        terrain_height,
    output logic [9:0]         column,
    output logic [9:0]         row,
    output logic               frame_done
);

    typedef enum logic [3:0] {
        B_IDLE, B_H1, B_H2, B_H3, B_SQ1, B_SQ2, B_SQ3, B_SUM,
        B_SETUP, B_CHK, B_T2, B_PLO, B_PHI, B_CMP, B_DONE
    } bstate_t;

    bstate_t state_reg, state_next;
    hne_req_t req_reg, req_next;
    logic [2:0] hidx_reg, hidx_next;
    logic [15:0] v_reg, v_next;
    logic [23:0] n_reg, n_next;
    logic [40:0] m_reg, m_next;
    logic [15:0] h_reg [5];
    logic [15:0] h_next [5];
    logic [15:0] mdx_reg, mdx_next;
    logic [15:0] mdz_reg, mdz_next;
    logic sx_reg, sx_next;
    logic sz_reg, sz_next;
    logic [31:0] dx2_reg, dx2_next;
    logic [31:0] dz2_reg, dz2_next;
    logic [33:0] s_reg, s_next;
    logic [1:0] comp_reg, comp_next;
    logic [61:0] rhs_reg, rhs_next;
    logic [14:0] lo_reg, lo_next;
    logic [14:0] hi_reg, hi_next;
    logic [14:0] mid_reg, mid_next;
    logic [29:0] t2_reg, t2_next;
    logic [46:0] plo_reg, plo_next;
    logic [46:0] phi_reg, phi_next;
    logic [14:0] qx_reg, qx_next;
    logic [14:0] qy_reg, qy_next;
    logic [14:0] qz_reg, qz_next;
    logic valid_reg, valid_next;
    logic signed [15:0] nx_reg, nx_next;
    logic [14:0] ny_reg, ny_next;
    logic signed [15:0] nz_reg, nz_next;
    logic [15:0] th_reg, th_next;
    logic [9:0] col_reg, col_next;
    logic [9:0] row_reg, row_next;
    logic done_reg, done_next;

    logic [7:0] cur_byte;
    logic [16:0] q0;
    logic [24:0] mul255;
    logic [24:0] rem;
    logic [16:0] hq;
    logic [16:0] hf;
    logic [16:0] dx;
    logic [16:0] dz;
    logic [31:0] mag2;
    logic [15:0] t;
    logic [63:0] prod;
    logic [15:0] mid_sum;

    always_comb
    begin
        case (hidx_reg)
            3'd0: cur_byte = req_reg.left;
            3'd1: cur_byte = req_reg.right;
            3'd2: cur_byte = req_reg.down;
            3'd3: cur_byte = req_reg.up;
            default: cur_byte = req_reg.center;
        endcase
    end

    assign q0 = m_reg[40:24];
    assign mul255 = {q0, 8'd0} - {8'd0, q0};
    assign rem = {1'b0, n_reg} - mul255;
    assign hq = (rem >= 25'd255) ? q0 + 17'd1 : q0;
    assign hf = (hq < {1'b0, cfg.height_floor, 8'd0}) ? {1'b0, cfg.height_floor, 8'd0} : hq;
    assign dx = {1'b0, h_reg[0]} - {1'b0, h_reg[1]};
    assign dz = {1'b0, h_reg[2]} - {1'b0, h_reg[3]};
    assign t = {mid_reg, 1'b0} - 16'd1;
    assign prod = {phi_reg, 17'd0} + {17'd0, plo_reg};
    assign mid_sum = ({1'b0, lo_reg} + {1'b0, hi_reg} + 16'd1) >> 1;

    always_comb
    begin
        case (comp_reg)
            2'd0: mag2 = dx2_reg;
            2'd1: mag2 = Y_TERM_SQ;
            default: mag2 = dz2_reg;
        endcase
    end

    assign pop = (state_reg == B_IDLE) && !empty;

    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        hidx_next = hidx_reg;
        v_next = v_reg;
        n_next = n_reg;
        m_next = m_reg;
        h_next = h_reg;
        mdx_next = mdx_reg;
        mdz_next = mdz_reg;
        sx_next = sx_reg;
        sz_next = sz_reg;
        dx2_next = dx2_reg;
        dz2_next = dz2_reg;
        s_next = s_reg;
        comp_next = comp_reg;
        rhs_next = rhs_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        t2_next = t2_reg;
        plo_next = plo_reg;
        phi_next = phi_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        qz_next = qz_reg;
        valid_next = valid_reg;
        nx_next = nx_reg;
        ny_next = ny_reg;
        nz_next = nz_reg;
        th_next = th_reg;
        col_next = col_reg;
        row_next = row_reg;
        done_next = done_reg;
        if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    req_next = head;
                    hidx_next = 3'd0;
                    state_next = B_H1;
                end
            end
            B_H1:
            begin
                v_next = {8'd0, cur_byte} * {8'd0, cfg.height_scale};
                state_next = B_H2;
            end
            B_H2:
            begin
                n_next = {v_reg, 8'h7F};
                m_next = {17'd0, v_reg, 8'h7F} * {24'd0, RECIP_255};
                state_next = B_H3;
            end
            B_H3:
            begin
                h_next[hidx_reg] = hf[16] ? 16'hFFFF : hf[15:0];
                if (hidx_reg == 3'd4)
                begin
                    state_next = B_SQ1;
                end
                else
                begin
                    hidx_next = hidx_reg + 3'd1;
                    state_next = B_H1;
                end
            end
            B_SQ1:
            begin
                sx_next = dx[16];
                sz_next = dz[16];
                mdx_next = dx[16] ? 16'(17'd0 - dx) : dx[15:0];
                mdz_next = dz[16] ? 16'(17'd0 - dz) : dz[15:0];
                state_next = B_SQ2;
            end
            B_SQ2:
            begin
                dx2_next = mdx_reg * mdx_reg;
                state_next = B_SQ3;
            end
            B_SQ3:
            begin
                dz2_next = mdz_reg * mdz_reg;
                state_next = B_SUM;
            end
            B_SUM:
            begin
                s_next = {2'd0, dx2_reg} + {2'd0, dz2_reg} + {2'd0, Y_TERM_SQ};
                comp_next = 2'd0;
                state_next = B_SETUP;
            end
            B_SETUP:
            begin
                rhs_next = {mag2, 30'd0};
                lo_next = 15'd0;
                hi_next = ONE_Q14;
                state_next = B_CHK;
            end
            B_CHK:
            begin
                if (lo_reg == hi_reg)
                begin
                    case (comp_reg)
                        2'd0: qx_next = lo_reg;
                        2'd1: qy_next = lo_reg;
                        default: qz_next = lo_reg;
                    endcase
                    if (comp_reg == 2'd2)
                    begin
                        state_next = B_DONE;
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                        state_next = B_SETUP;
                    end
                end
                else
                begin
                    mid_next = mid_sum[14:0];
                    state_next = B_T2;
                end
            end
            B_T2:
            begin
                t2_next = 30'(t * t);
                state_next = B_PLO;
            end
            B_PLO:
            begin
                plo_next = {17'd0, t2_reg} * {30'd0, s_reg[16:0]};
                state_next = B_PHI;
            end
            B_PHI:
            begin
                phi_next = {17'd0, t2_reg} * {30'd0, s_reg[33:17]};
                state_next = B_CMP;
            end
            B_CMP:
            begin
                if (prod <= {2'd0, rhs_reg})
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg - 15'd1;
                end
                state_next = B_CHK;
            end
            B_DONE:
            begin
                if (!valid_reg || !result_stall)
                begin
                    valid_next = 1'b1;
                    nx_next = sx_reg ? 16'd0 - {1'b0, qx_reg} : {1'b0, qx_reg};
                    ny_next = qy_reg;
                    nz_next = sz_reg ? 16'd0 - {1'b0, qz_reg} : {1'b0, qz_reg};
                    th_next = h_reg[4];
                    col_next = req_reg.col;
                    row_next = req_reg.row;
                    done_next = req_reg.done;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        hidx_reg <= hidx_next;
        v_reg <= v_next;
        n_reg <= n_next;
        m_reg <= m_next;
        h_reg <= h_next;
        mdx_reg <= mdx_next;
        mdz_reg <= mdz_next;
        sx_reg <= sx_next;
        sz_reg <= sz_next;
        dx2_reg <= dx2_next;
        dz2_reg <= dz2_next;
        s_reg <= s_next;
        comp_reg <= comp_next;
        rhs_reg <= rhs_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        t2_reg <= t2_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        qz_reg <= qz_next;
        nx_reg <= nx_next;
        ny_reg <= ny_next;
        nz_reg <= nz_next;
        th_reg <= th_next;
        col_reg <= col_next;
        row_reg <= row_next;
        done_reg <= done_next;
    end

    assign result_valid = valid_reg;
    assign normal_x = nx_reg;
    assign normal_y = ny_reg;
    assign normal_z = nz_reg;
    assign terrain_height = th_reg;
    assign column = col_reg;
    assign row = row_reg;
    assign frame_done = done_reg;

endmodule

// ----- hdl/hne_checker.sv -----
// Port-level checker for the heightmap normal engine, bound to the top level.
module hne_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [15:0] normal_x,
    input logic [14:0]        normal_y,
    input logic signed [15:0] normal_z,
    input logic [15:0]        terrain_height,
    input logic [9:0]         column,
    input logic [9:0]         row,
    input logic               frame_done
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(normal_x)
            && $stable(normal_y) && $stable(normal_z) && $stable(terrain_height)
            && $stable(column) && $stable(row) && $stable(frame_done))
        else $error("Stalled result changed.");

    a_up: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> normal_y != 15'd0 && normal_y <= 15'd16384)
        else $error("Vertical component out of range.");

    a_side: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
            && normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
        else $error("Horizontal component out of range.");

    a_flat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && normal_x == 16'sd0 && normal_z == 16'sd0 |-> normal_y == 15'd16384)
        else $error("Flat normal is not vertical.");

endmodule

bind heightmap_normal_engine_core hne_checker u_hne_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the heightmap normal engine core.
`timescale 1ns / 100ps

module tb_top;
    import hne_pkg::*;

    localparam int STALL_LIMIT = 100000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic signed [15:0] nx;
        logic [14:0]        ny;
        logic signed [15:0] nz;
        logic [15:0]        height;
        logic [9:0]         col;
        logic [9:0]         row;
        logic               done;
    } normal_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [10:0] val;
        logic [7:0]  pixel;
        bit          flat;
        logic [15:0] height;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [10:0] cfg_data = '0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic [7:0] sample = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [15:0] normal_x;
    logic [14:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0] terrain_height;
    logic [9:0] column;
    logic [9:0] row;
    logic frame_done;

    heightmap_normal_engine_core DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the block state used by the normal predictor.
    logic [7:0] line_older [0:1023];
    logic [7:0] line_prev [0:1023];
    logic [7:0] line_cur [0:1023];
    int unsigned col_pos, row_pos;
    int unsigned width_reg = RST_FRAME_WIDTH, height_reg = RST_FRAME_HEIGHT;
    int unsigned scale_reg = RST_HEIGHT_SCALE, floor_reg = RST_HEIGHT_FLOOR;

    normal_t pending_normals[$];
    int idle_pct = 0, stall_pct = 0;
    int mismatches = 0, unexpected = 0, results_seen = 0, frames_seen = 0;
    int items_sent = 0, quiet_cycles = 0;

    function automatic int unsigned height_of(logic [7:0] b);
        int unsigned h, f;
        h = (b * scale_reg * 256 + 127) / 255;
        f = floor_reg << 8;
        if (h < f) h = f;
        if (h > 65535) h = 65535;
        return h;
    endfunction

    function automatic int unit_q14(int d, longint unsigned s);
        longint unsigned mag, a, rhs, t;
        int unsigned lo, hi, mid;
        mag = (d < 0) ? -d : d;
        a = mag * 16384;
        rhs = 4 * a * a;
        lo = 0;
        hi = ONE_Q14;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            t = 2 * longint'(mid) - 1;
            if (t * t * s <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return (d < 0) ? -int'(lo) : int'(lo);
    endfunction

    function automatic normal_t surface_normal(logic [7:0] l, logic [7:0] r, logic [7:0] dn,
                                               logic [7:0] up, logic [7:0] c,
                                               int unsigned x, int unsigned z, bit done);
        normal_t n;
        int dx, dz;
        longint unsigned s;
        dx = int'(height_of(l)) - int'(height_of(r));
        dz = int'(height_of(dn)) - int'(height_of(up));
        s = longint'(dx) * dx + 262144 + longint'(dz) * dz;
        n.nx = 16'(unit_q14(dx, s));
        n.ny = 15'(unit_q14(512, s));
        n.nz = 16'(unit_q14(dz, s));
        n.height = 16'(height_of(c));
        n.col = 10'(x);
        n.row = 10'(z);
        n.done = done;
        return n;
    endfunction

    task automatic predict_normals(logic [7:0] b, bit flat, logic [15:0] flat_height);
        int unsigned w, h, x, z, xl, xr, px, pl;
        normal_t got[$];
        logic [7:0] dn;
        w = (width_reg < 2) ? 2 : (width_reg > 1024 ? 1024 : width_reg);
        h = (height_reg < 2) ? 2 : (height_reg > 1024 ? 1024 : height_reg);
        x = (col_pos >= w) ? w - 1 : col_pos;
        z = row_pos;
        line_cur[x] = b;
        if (z >= 1)
        begin
            xl = (x != 0) ? x - 1 : x;
            xr = (x + 1 < w) ? x + 1 : x;
            dn = (z == 1) ? line_prev[x] : line_older[x];
            got = {got, surface_normal(line_prev[xl], line_prev[xr], dn, b,
                                       line_prev[x], x, z - 1, 1'b0)};
        end
        if (z == h - 1)
        begin
            if (x >= 1)
            begin
                px = x - 1;
                pl = (px != 0) ? px - 1 : px;
                got = {got, surface_normal(line_cur[pl], b, line_prev[px], line_cur[px],
                                           line_cur[px], px, z, 1'b0)};
            end
            if (x == w - 1)
                got = {got, surface_normal(line_cur[x - 1], b, line_prev[x], b, b,
                                           x, z, 1'b1)};
        end
        foreach (got[i])
        begin
            if (flat)
            begin
                got[i].nx = '0;
                got[i].ny = ONE_Q14;
                got[i].nz = '0;
                got[i].height = flat_height;
            end
            pending_normals = {pending_normals, got[i]};
        end
        x++;
        if (x >= w)
        begin
            line_older = line_prev;
            line_prev = line_cur;
            x = 0;
            z++;
            if (z >= h) z = 0;
        end
        col_pos = x;
        row_pos = z;
    endtask

    task automatic send_pixel(logic [7:0] b, bit flat = 1'b0, logic [15:0] flat_height = '0);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= b;
        @(negedge clk);
        while (sample_stall) @(negedge clk);
        @(posedge clk);
        predict_normals(b, flat, flat_height);
        items_sent++;
    endtask

    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  begin width_reg = val; col_pos = 0; row_pos = 0; end
            CFG_FRAME_HEIGHT: begin height_reg = val; col_pos = 0; row_pos = 0; end
            CFG_HEIGHT_SCALE: scale_reg = val[7:0];
            CFG_HEIGHT_FLOOR: floor_reg = val[7:0];
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        normal_t want, seen;
        if (result_valid && !result_stall)
        begin
            seen = '{normal_x, normal_y, normal_z, terrain_height, column, row, frame_done};
            results_seen++;
            if (frame_done) frames_seen++;
            if (pending_normals.size() == 0)
            begin
                unexpected++;
                if (unexpected + mismatches <= 10)
                    $display("Unexpected result: %p", seen);
            end
            else
            begin
                want = pending_normals.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (unexpected + mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, seen);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding.", pending_normals.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        step_t steps[$];
        int widths[8] = '{0, 2, 3, 4, 5, 7, 9, 16};
        int heights[5] = '{1, 2, 3, 4, 6};
        int phase, w, h, count;
        steps = '{
            '{1, CFG_FRAME_WIDTH, 11'd2, 0, 0, 0}, '{1, CFG_FRAME_HEIGHT, 11'd2, 0, 0, 0},
            '{1, CFG_HEIGHT_SCALE, 11'd255, 0, 0, 0}, '{1, CFG_HEIGHT_FLOOR, 11'd0, 0, 0, 0},
            '{0, 0, 0, 8'd0, 1, 16'd0}, '{0, 0, 0, 8'd0, 1, 16'd0},
            '{0, 0, 0, 8'd0, 1, 16'd0}, '{0, 0, 0, 8'd0, 1, 16'd0},
            '{0, 0, 0, 8'd255, 0, 0}, '{0, 0, 0, 8'd0, 0, 0},
            '{0, 0, 0, 8'd0, 0, 0}, '{0, 0, 0, 8'd255, 0, 0},
            '{1, CFG_HEIGHT_FLOOR, 11'd255, 0, 0, 0},
            '{0, 0, 0, 8'd255, 1, 16'd65280}, '{0, 0, 0, 8'd0, 1, 16'd65280},
            '{0, 0, 0, 8'd0, 1, 16'd65280}, '{0, 0, 0, 8'd255, 1, 16'd65280},
            '{1, CFG_HEIGHT_SCALE, 11'd0, 0, 0, 0}, '{1, CFG_HEIGHT_FLOOR, 11'd0, 0, 0, 0},
            '{0, 0, 0, 8'd170, 1, 16'd0}, '{0, 0, 0, 8'd85, 1, 16'd0},
            '{0, 0, 0, 8'd15, 1, 16'd0}, '{0, 0, 0, 8'd240, 1, 16'd0}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
            begin
                wait_idle();
                write_reg(steps[i].idx, steps[i].val);
            end
            else
                send_pixel(steps[i].pixel, steps[i].flat, steps[i].height);
        end

        count = 0;
        phase = 0;
        while (count < RANDOM_ITEMS)
        begin
            wait_idle();
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            w = widths[$urandom_range(7)];
            h = heights[$urandom_range(4)];
            write_reg(CFG_FRAME_WIDTH, 11'(w));
            write_reg(CFG_FRAME_HEIGHT, 11'(h));
            write_reg(CFG_HEIGHT_SCALE,
                      11'(($urandom_range(4) == 0) ? 255 : $urandom_range(255)));
            write_reg(CFG_HEIGHT_FLOOR,
                      11'(($urandom_range(4) == 0) ? 0 : $urandom_range(255)));
            w = (w < 2) ? 2 : w;
            h = (h < 2) ? 2 : h;
            w = w * h * $urandom_range(1, 2) - (($urandom_range(3) == 0) ? $urandom_range(w) : 0);
            for (int i = 0; i < w; i++)
            begin
                if (phase == 3 && i == w / 2)
                begin
                    sample_valid <= 1'b0;
                    while (pending_normals.size() != 0) @(posedge clk);
                end
                send_pixel(($urandom_range(2) == 0) ? 8'($urandom_range(100, 110))
                                                    : 8'($urandom_range(255)));
            end
            count += w;
            phase++;
        end

        sample_valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d heightmap samples over %0d random geometry settings.",
                 items_sent, phase);
        $display("Checked %0d normals, %0d complete frames, %0d mismatches, %0d unexpected.",
                 results_seen, frames_seen, mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/hne_pkg.sv
hdl/hne_ram.sv
hdl/hne_front.sv
hdl/hne_queue.sv
hdl/hne_back.sv
hdl/heightmap_normal_engine_core.sv
hdl/hne_checker.sv
dv/tb_top.sv
